// File: hdl/tpc_pkg.sv
// ----------------------------------------------------------------------------
// tpc_pkg: shared types and constants for the triangle plane clipper
// Coordinate formats, queue entry layout, clip kinds and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package tpc_pkg;

  localparam int CW     = 32;           // coordinate width, signed fixed point
  localparam int FB     = 16;           // fractional bits
  localparam int PROD_W = 2 * CW;       // one coefficient * coordinate product
  localparam int E_W    = 2 * CW + 2;   // signed plane distance, s - (d << FB)
  localparam int DEN_W  = E_W + 1;      // unsigned divider operands
  localparam int PRD_W  = FB + CW + 2;  // t * (Q - P) plus rounding
  localparam int SUM_W  = CW + 3;       // P + scaled product, before clamp

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam int CFG_IW = 2;
  localparam logic [CFG_IW-1:0] REG_PLANE_A = 2'd0;
  localparam logic [CFG_IW-1:0] REG_PLANE_B = 2'd1;
  localparam logic [CFG_IW-1:0] REG_PLANE_C = 2'd2;
  localparam logic [CFG_IW-1:0] REG_PLANE_D = 2'd3;

  // clip kinds carried through the queue
  localparam logic [1:0] KIND_PASS = 2'd0;
  localparam logic [1:0] KIND_ONE  = 2'd1;
  localparam logic [1:0] KIND_TWO  = 2'd2;

  // vertex: [0] = x, [1] = y, [2] = z
  typedef logic [2:0][CW-1:0] vert_t;

  typedef struct packed {
    logic [CW-1:0] v0_x;
    logic [CW-1:0] v0_y;
    logic [CW-1:0] v0_z;
    logic [CW-1:0] v1_x;
    logic [CW-1:0] v1_y;
    logic [CW-1:0] v1_z;
    logic [CW-1:0] v2_x;
    logic [CW-1:0] v2_y;
    logic [CW-1:0] v2_z;
  } tri_in_t;

  typedef struct packed {
    logic [CW-1:0] out0_x;
    logic [CW-1:0] out0_y;
    logic [CW-1:0] out0_z;
    logic [CW-1:0] out1_x;
    logic [CW-1:0] out1_y;
    logic [CW-1:0] out1_z;
    logic [CW-1:0] out2_x;
    logic [CW-1:0] out2_y;
    logic [CW-1:0] out2_z;
    logic          last_of_run;
  } tri_out_t;

  typedef struct packed {
    logic [CW-1:0] a;
    logic [CW-1:0] b;
    logic [CW-1:0] c;
    logic [CW-1:0] d;
  } plane_t;

  // vertices in role order: ONE = I0,O0,O1  TWO = I0,I1,O0  PASS = input order
  typedef struct packed {
    logic [1:0]              kind;
    logic [2:0][2:0][CW-1:0] v;
    logic [2:0][E_W-1:0]     e;
  } q_entry_t;

  typedef struct packed {
    logic     vld;
    q_entry_t ent;
  } q_wr_t;

endpackage

`default_nettype wire

// File: hdl/tpc_div.sv
// ----------------------------------------------------------------------------
// tpc_div: pipelined restoring divider
// One quotient bit per stage; yields floor(num * 2^FB / den) for num < den.
// ----------------------------------------------------------------------------
`default_nettype none

module tpc_div (
  input  logic                     clk,
  input  logic [tpc_pkg::DEN_W-1:0] num,
  input  logic [tpc_pkg::DEN_W-1:0] den,
  output logic [tpc_pkg::FB-1:0]    quo
);
  import tpc_pkg::*;

  logic [DEN_W-1:0] rem_r [FB-1];
  logic [DEN_W-1:0] den_r [FB-1];
  logic [FB-1:0]    q_r   [FB];

  for (genvar j = 0; j < FB; j++) begin : g_step
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [FB-1:0]    q_in;
    logic [DEN_W:0]   sh;
    logic [DEN_W:0]   dif;
    logic             ge;

    if (j == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_rest
      assign rem_in = rem_r[j-1];
      assign den_in = den_r[j-1];
      assign q_in   = q_r[j-1];
    end

    assign sh  = {rem_in, 1'b0};
    assign ge  = (sh >= {1'b0, den_in});
    assign dif = sh - {1'b0, den_in};

    always_ff @(posedge clk) begin
      q_r[j] <= {q_in[FB-2:0], ge};
    end

    if (j < FB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[j] <= ge ? dif[DEN_W-1:0] : sh[DEN_W-1:0];
        den_r[j] <= den_in;
      end
    end
  end

  assign quo = q_r[FB-1];

endmodule

`default_nettype wire

// File: hdl/tpc_fifo.sv
// ----------------------------------------------------------------------------
// tpc_fifo: short queue between classifier and clip back end
// Register based, one write and one read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tpc_fifo (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tpc_pkg::q_wr_t           wr,
  input  logic                     rd,
  output tpc_pkg::q_entry_t        rd_data,
  output logic [tpc_pkg::Q_CW-1:0] count
);
  import tpc_pkg::*;

  q_entry_t         mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wp_r, wp_nxt;
  logic [Q_AW-1:0]  rp_r, rp_nxt;
  logic [Q_CW-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wr.vld ? wp_r + 1'b1 : wp_r;
    rp_nxt  = rd ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + Q_CW'(wr.vld) - Q_CW'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.vld) begin
      mem_r[wp_r] <= wr.ent;
    end
  end

  assign rd_data = mem_r[rp_r];
  assign count   = cnt_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr.vld && !rd && cnt_r == Q_CW'(Q_DEPTH)))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd && cnt_r == '0))
    else $error("queue read while empty");

endmodule

`default_nettype wire

// File: hdl/tpc_front.sv
// ----------------------------------------------------------------------------
// tpc_front: plane distance and classification
// Multiplies, sums against the offset, sorts vertices into role order.
// ----------------------------------------------------------------------------
`default_nettype none

module tpc_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  tpc_pkg::tri_in_t         in_tri,
  input  tpc_pkg::plane_t          plane,
  input  logic [tpc_pkg::Q_CW-1:0] q_count,
  output tpc_pkg::q_wr_t           q_wr
);
  import tpc_pkg::*;

  logic [2:0][CW-1:0]     vin [3];
  logic                   s1_vld_r, s1_vld_nxt;
  vert_t                  s1_v_r [3];
  logic [2:0][PROD_W-1:0] s1_p_r [3];
  logic                   s2_vld_r;
  vert_t                  s2_v_r [3];
  logic [2:0][E_W-1:0]    s2_e_r, s2_e_nxt;
  logic signed [E_W-1:0]  dsc;
  logic [Q_CW:0]          occ;
  logic [2:0]             inflag;
  logic [1:0]             r0, r1, r2;
  logic [1:0]             kind;
  logic                   keep;

  assign vin[0] = {in_tri.v0_z, in_tri.v0_y, in_tri.v0_x};
  assign vin[1] = {in_tri.v1_z, in_tri.v1_y, in_tri.v1_x};
  assign vin[2] = {in_tri.v2_z, in_tri.v2_y, in_tri.v2_x};

  // reserve a queue slot for everything already in flight
  assign occ = {1'b0, q_count} + {{Q_CW{1'b0}}, s1_vld_r} + {{Q_CW{1'b0}}, s2_vld_r};
  assign busy = (occ >= (Q_CW+1)'(Q_DEPTH));
  assign s1_vld_nxt = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s1_vld_r;
    end
  end

  // stage 1: nine products
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s1_v_r[i]    <= vin[i];
      s1_p_r[i][0] <= $signed(plane.a) * $signed(vin[i][0]);
      s1_p_r[i][1] <= $signed(plane.b) * $signed(vin[i][1]);
      s1_p_r[i][2] <= $signed(plane.c) * $signed(vin[i][2]);
    end
  end

  // stage 2: distance from the plane offset
  assign dsc = E_W'($signed(plane.d)) <<< FB;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_e_nxt[i] = E_W'($signed(s1_p_r[i][0])) + E_W'($signed(s1_p_r[i][1]))
                  + E_W'($signed(s1_p_r[i][2])) - dsc;
    end
  end

  always_ff @(posedge clk) begin
    s2_v_r <= s1_v_r;
    s2_e_r <= s2_e_nxt;
  end

  // classify and reorder into roles
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      inflag[i] = ~s2_e_r[i][E_W-1];
    end
    keep = 1'b1;
    kind = KIND_PASS;
    r0   = 2'd0;
    r1   = 2'd1;
    r2   = 2'd2;
    case (inflag)
      3'b001: begin kind = KIND_ONE; end
      3'b010: begin kind = KIND_ONE; r0 = 2'd1; r1 = 2'd0; end
      3'b100: begin kind = KIND_ONE; r0 = 2'd2; r1 = 2'd0; r2 = 2'd1; end
      3'b011: begin kind = KIND_TWO; end
      3'b101: begin kind = KIND_TWO; r1 = 2'd2; r2 = 2'd1; end
      3'b110: begin kind = KIND_TWO; r0 = 2'd1; r1 = 2'd2; r2 = 2'd0; end
      3'b111: begin kind = KIND_PASS; end
      default: begin keep = 1'b0; end
    endcase
  end

  always_comb begin
    q_wr.vld       = s2_vld_r && keep;
    q_wr.ent.kind  = kind;
    q_wr.ent.v[0]  = s2_v_r[r0];
    q_wr.ent.v[1]  = s2_v_r[r1];
    q_wr.ent.v[2]  = s2_v_r[r2];
    q_wr.ent.e[0]  = s2_e_r[r0];
    q_wr.ent.e[1]  = s2_e_r[r1];
    q_wr.ent.e[2]  = s2_e_r[r2];
  end

endmodule

`default_nettype wire

// File: hdl/tpc_back.sv
// ----------------------------------------------------------------------------
// tpc_back: edge intersection and triangle emission
// Two divider pipelines, interpolation, clamp, one or two output triangles.
// ----------------------------------------------------------------------------
`default_nettype none

module tpc_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tpc_pkg::q_entry_t        rd_data,
  input  logic [tpc_pkg::Q_CW-1:0] q_count,
  output logic                     q_rd,
  output logic                     out_strobe,
  output tpc_pkg::tri_out_t        out_tri
);
  import tpc_pkg::*;

  typedef struct packed {
    logic [1:0]         kind;
    vert_t              p0;
    vert_t              p1;
    vert_t              r2;
    logic [2:0][CW:0]   d0;
    logic [2:0][CW:0]   d1;
  } side_t;

  localparam logic signed [PRD_W-1:0] HALF = PRD_W'(1) <<< (FB - 1);

  function automatic logic [CW-1:0] sat_coord(input logic [SUM_W-1:0] v);
    logic [CW-1:0] r;
    if (v[SUM_W-1:CW-1] == '0 || v[SUM_W-1:CW-1] == '1) begin
      r = v[CW-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(CW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CW-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic tri_out_t mk_tri(input vert_t a, input vert_t b, input vert_t c,
                                      input logic last);
    tri_out_t t;
    t.out0_x = a[0]; t.out0_y = a[1]; t.out0_z = a[2];
    t.out1_x = b[0]; t.out1_y = b[1]; t.out1_z = b[2];
    t.out2_x = c[0]; t.out2_y = c[1]; t.out2_z = c[2];
    t.last_of_run = last;
    return t;
  endfunction

  logic                 pop_last_r;
  logic                 one;
  vert_t                pv1, qv0;
  logic [E_W-1:0]       ep1, eq0;
  side_t                side_nxt;
  logic [DEN_W-1:0]     num_nxt [2];
  logic [DEN_W-1:0]     den_nxt [2];

  logic                 p_vld_r;
  logic [DEN_W-1:0]     p_num_r [2];
  logic [DEN_W-1:0]     p_den_r [2];
  side_t                p_side_r;

  logic [FB-1:0]        t0, t1;
  logic [FB-1:0]        dv_r;
  side_t                side_r [FB];

  logic                 i1_vld_r;
  side_t                i1_side_r;
  logic [2:0][PRD_W-1:0] i1_prd0_r, i1_prd1_r;

  vert_t                x0, x1;
  tri_out_t             first, second;
  logic                 out_vld_r, out_vld_nxt;
  tri_out_t             out_r, out_nxt;
  logic                 sec_vld_r, sec_vld_nxt;
  tri_out_t             sec_r;

  // the queue is never popped directly after a pop
  assign q_rd = (q_count != '0) && !pop_last_r;

  // crossing 0 = (P0,Q0), crossing 1 = (P1,Q1)
  always_comb begin
    one = (rd_data.kind == KIND_ONE);
    pv1 = one ? rd_data.v[0] : rd_data.v[1];
    qv0 = one ? rd_data.v[1] : rd_data.v[2];
    ep1 = one ? rd_data.e[0] : rd_data.e[1];
    eq0 = one ? rd_data.e[1] : rd_data.e[2];
    num_nxt[0] = DEN_W'($signed(rd_data.e[0]));
    den_nxt[0] = DEN_W'($signed(rd_data.e[0])) - DEN_W'($signed(eq0));
    num_nxt[1] = DEN_W'($signed(ep1));
    den_nxt[1] = DEN_W'($signed(ep1)) - DEN_W'($signed(rd_data.e[2]));
    side_nxt.kind = rd_data.kind;
    side_nxt.p0   = rd_data.v[0];
    side_nxt.p1   = pv1;
    side_nxt.r2   = rd_data.v[2];
    for (int c = 0; c < 3; c++) begin
      side_nxt.d0[c] = (CW+1)'($signed(qv0[c])) - (CW+1)'($signed(rd_data.v[0][c]));
      side_nxt.d1[c] = (CW+1)'($signed(rd_data.v[2][c])) - (CW+1)'($signed(pv1[c]));
    end
  end

  always_ff @(posedge clk) begin
    p_num_r[0] <= num_nxt[0];
    p_den_r[0] <= den_nxt[0];
    p_num_r[1] <= num_nxt[1];
    p_den_r[1] <= den_nxt[1];
    p_side_r   <= side_nxt;
  end

  tpc_div u_div0 (.clk(clk), .num(p_num_r[0]), .den(p_den_r[0]), .quo(t0));
  tpc_div u_div1 (.clk(clk), .num(p_num_r[1]), .den(p_den_r[1]), .quo(t1));

  // vertex data rides alongside the dividers
  always_ff @(posedge clk) begin
    side_r[0] <= p_side_r;
    for (int j = 1; j < FB; j++) begin
      side_r[j] <= side_r[j-1];
    end
  end

  // interpolation products, rounding offset folded in
  always_ff @(posedge clk) begin
    i1_side_r <= side_r[FB-1];
    for (int c = 0; c < 3; c++) begin
      i1_prd0_r[c] <= PRD_W'($signed({1'b0, t0})) * PRD_W'($signed(side_r[FB-1].d0[c]))
                    + HALF;
      i1_prd1_r[c] <= PRD_W'($signed({1'b0, t1})) * PRD_W'($signed(side_r[FB-1].d1[c]))
                    + HALF;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      x0[c] = sat_coord(SUM_W'($signed(i1_side_r.p0[c]))
                      + SUM_W'($signed(i1_prd0_r[c]) >>> FB));
      x1[c] = sat_coord(SUM_W'($signed(i1_side_r.p1[c]))
                      + SUM_W'($signed(i1_prd1_r[c]) >>> FB));
    end
    second = mk_tri(i1_side_r.p1, x0, x1, 1'b1);
    case (i1_side_r.kind)
      KIND_ONE: first = mk_tri(i1_side_r.p0, x0, x1, 1'b1);
      KIND_TWO: first = mk_tri(i1_side_r.p0, x0, i1_side_r.p1, 1'b0);
      default:  first = mk_tri(i1_side_r.p0, i1_side_r.p1, i1_side_r.r2, 1'b1);
    endcase
    out_vld_nxt = i1_vld_r || sec_vld_r;
    out_nxt     = i1_vld_r ? first : sec_r;
    sec_vld_nxt = i1_vld_r && (i1_side_r.kind == KIND_TWO);
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (i1_vld_r) begin
      sec_r <= second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_last_r <= 1'b0;
      p_vld_r    <= 1'b0;
      dv_r       <= '0;
      i1_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      sec_vld_r  <= 1'b0;
    end else begin
      pop_last_r <= q_rd;
      p_vld_r    <= q_rd;
      dv_r       <= {dv_r[FB-2:0], p_vld_r};
      i1_vld_r   <= dv_r[FB-1];
      out_vld_r  <= out_vld_nxt;
      sec_vld_r  <= sec_vld_nxt;
    end
  end

  assign out_strobe = out_vld_r;
  assign out_tri    = out_r;

  a_pop_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd |=> !q_rd)
    else $error("queue popped on consecutive cycles");

  a_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    !(i1_vld_r && sec_vld_r))
    else $error("new triangle collides with pending second triangle");

endmodule

`default_nettype wire

// File: hdl/triangle_plane_clipper_top.sv
// ----------------------------------------------------------------------------
// triangle_plane_clipper_top: clips a triangle against a*x + b*y + c*z >= d
// A second result triangle of the same input follows in the cycle after the first;
//   the input rate is set by the back end, which never takes a queue entry directly
//   after another, so that its single result port stays free.
// Reset: synchronous, active low; clears all control and loads plane defaults.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_plane_clipper_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // input transaction
  input  logic                          start,
  output logic                          busy,
  input  tpc_pkg::tri_in_t              in_tri,
  // result transaction
  output logic                          out_strobe,
  output tpc_pkg::tri_out_t             out_tri,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [tpc_pkg::CFG_IW-1:0]    cfg_idx,
  input  logic [tpc_pkg::CW-1:0]        cfg_data
);
  import tpc_pkg::*;

  // plane registers; the user must write them only while the block is idle (not enforced)
  plane_t          plane_r, plane_nxt;

  q_wr_t           q_wr;
  q_entry_t        q_rd_data;
  logic            q_rd;
  logic [Q_CW-1:0] q_count;

  always_comb begin
    plane_nxt = plane_r;
    if (cfg_we) begin
      case (cfg_idx)
        REG_PLANE_A: plane_nxt.a = cfg_data;
        REG_PLANE_B: plane_nxt.b = cfg_data;
        REG_PLANE_C: plane_nxt.c = cfg_data;
        REG_PLANE_D: plane_nxt.d = cfg_data;
        default:     plane_nxt = plane_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r.a <= '0;
      plane_r.b <= '0;
      plane_r.c <= CW'(1) << FB;          // unit z normal
      plane_r.d <= CW'(6554);             // about 0.1
    end else begin
      plane_r <= plane_nxt;
    end
  end

  // front end: products, distances, classification; drops fully clipped
  // triangles and pushes the rest into the queue in role order
  tpc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_tri  (in_tri),
    .plane   (plane_r),
    .q_count (q_count),
    .q_wr    (q_wr)
  );

  // short queue decouples classification from the intersection pipeline
  tpc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .rd      (q_rd),
    .rd_data (q_rd_data),
    .count   (q_count)
  );

  // back end: computes both edge crossings of each queue entry, then emits one or two triangles
  tpc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_data    (q_rd_data),
    .q_count    (q_count),
    .q_rd       (q_rd),
    .out_strobe (out_strobe),
    .out_tri    (out_tri)
  );

endmodule

`default_nettype wire
